// File: rtl/loht_pkg.sv
// shared types and constants for the lru open handle tracker
`default_nettype none
package loht_pkg;

  localparam int SLOTS_DEF      = 32;
  localparam int OWNER_BITS_DEF = 8;
  localparam logic [5:0] MAX_OPEN_RESET = 6'd16;

  typedef enum logic [2:0] {
    ACT_REGISTER   = 3'd0,
    ACT_UNREGISTER = 3'd1,
    ACT_USE        = 3'd2,
    ACT_CLOSE      = 3'd3,
    ACT_RELEASE    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    KIND_ALLOC    = 3'd0,
    KIND_RELEASED = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_MISMATCH = 3'd3,
    KIND_FULL     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] slot;
    logic [7:0] owner;
  } in_word_t;

  typedef struct packed {
    logic [4:0] result_slot;
    logic [2:0] kind;
    logic       last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UNLINK_RD,
    ST_UNLINK_WR,
    ST_PUSH,
    ST_EVICT,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/lru_open_handle_tracker.sv
// top level of the lru open handle tracker
//
// Tracks up to SLOTS handle slots with owners, plus a newest-to-oldest recency
// list capped by cfg max_open. Owners and list links live in registered-read
// memories; the sequencer handles one word at a time. Register picks the
// lowest free slot from the used bits combinationally. Unregister and close
// unlink the slot when it is listed; a use of a listed slot unlinks it and
// pushes it as newest, and a use of an unlisted slot first evicts the oldest
// while the list is at capacity. Release-owner walks every slot through the
// owner memory and unlinks each released listed slot. Results leave through
// an output register, one word at a time; every result word that waits on
// out_ready adds the stall, and a new word is only taken once the sequencer
// is idle and the output register is free or drains.
`default_nettype none
module lru_open_handle_tracker
  import loht_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [5:0] cfg_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // memories
  logic [OWNER_BITS-1:0] owner_mem [SLOTS];
  logic [SW-1:0]         newer_mem [SLOTS];
  logic [SW-1:0]         older_mem [SLOTS];
  logic [OWNER_BITS-1:0] owner_rd_r;
  logic [SW-1:0]         newer_rd_r, older_rd_r;

  logic [SLOTS-1:0] used_r, used_nxt;
  logic [SLOTS-1:0] inl_r, inl_nxt;
  logic [SW-1:0]    newest_r, newest_nxt, oldest_r, oldest_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [5:0]       max_open_r;

  state_t state_r, state_nxt;
  logic [2:0]  act_r, act_nxt;
  logic [4:0]  slot_in_r, slot_in_nxt;
  logic [OWNER_BITS-1:0] own_r, own_nxt;
  logic [SW-1:0] tgt_r, tgt_nxt;      // slot being unlinked
  logic [SW-1:0] scan_r, scan_nxt;
  logic          scan_done_r, scan_done_nxt;
  state_t        ret_r, ret_nxt;      // state after unlink

  out_word_t ob_r, ob_nxt;
  logic      ov_r, ov_nxt;

  // memory ports
  logic              o_we, n_we, d_we;
  logic [SW-1:0]     o_wa, n_wa, d_wa;
  logic [OWNER_BITS-1:0] o_wd;
  logic [SW-1:0]     n_wd, d_wd;
  logic [SW-1:0]     o_ra, l_ra;

  // capacity after clamping
  logic [6:0] cap;
  always_comb begin
    if (max_open_r == 6'd0) cap = 7'd1;
    else if (32'(max_open_r) > SLOTS) cap = 7'(SLOTS);
    else cap = {1'b0, max_open_r};
  end

  // lowest free slot
  logic [SW-1:0] free_idx;
  logic          free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  logic in_range;
  logic [SW-1:0] s_idx;
  assign in_range = 32'(slot_in_r) < SLOTS;
  assign s_idx    = SW'(slot_in_r);

  always_ff @(posedge clk) begin
    if (o_we) owner_mem[o_wa] <= o_wd;
    owner_rd_r <= owner_mem[o_ra];
  end

  // link memories, at most one write each per cycle
  always_ff @(posedge clk) begin
    if (n_we)  newer_mem[n_wa]  <= n_wd;
    if (d_we)  older_mem[d_wa]  <= d_wd;
    newer_rd_r <= newer_mem[l_ra];
    older_rd_r <= older_mem[l_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      inl_r       <= '0;
      newest_r    <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      ov_r        <= 1'b0;
      max_open_r  <= MAX_OPEN_RESET;
      ret_r       <= ST_IDLE;
      scan_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      inl_r       <= inl_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      ov_r        <= ov_nxt;
      ret_r       <= ret_nxt;
      scan_done_r <= scan_done_nxt;
      if (cfg_we) max_open_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    slot_in_r <= slot_in_nxt;
    own_r     <= own_nxt;
    tgt_r     <= tgt_nxt;
    scan_r    <= scan_nxt;
    ob_r      <= ob_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = ob_r;
  // a new word only when the sequencer is idle and the output register is free or drains this cycle
  assign in_ready  = (state_r == ST_IDLE) && (!ov_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r; slot_in_nxt = slot_in_r; own_nxt = own_r;
    tgt_nxt = tgt_r; scan_nxt = scan_r; scan_done_nxt = scan_done_r;
    ret_nxt = ret_r;
    used_nxt = used_r; inl_nxt = inl_r;
    newest_nxt = newest_r; oldest_nxt = oldest_r; count_nxt = count_r;
    ob_nxt = ob_r; ov_nxt = ov_r;
    o_we = 1'b0; o_wa = '0; o_wd = '0;
    n_we = 1'b0; n_wa = '0; n_wd = '0;
    d_we = 1'b0; d_wa = '0; d_wd = '0;
    o_ra = s_idx; l_ra = tgt_r;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        o_ra = SW'(in_data.slot);
        if (in_valid && in_ready) begin
          act_nxt = in_data.action;
          slot_in_nxt = in_data.slot;
          own_nxt = OWNER_BITS'(in_data.owner);
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        // owner of named slot is now in owner_rd_r
        tgt_nxt = s_idx;
        case (act_r)
          ACT_REGISTER: begin
            if (!free_any) begin
              ob_nxt = '{result_slot: 5'd0, kind: KIND_FULL, last: 1'b1};
            end else begin
              used_nxt[free_idx] = 1'b1;
              o_we = 1'b1; o_wa = free_idx; o_wd = own_r;
              ob_nxt = '{result_slot: 5'(free_idx), kind: KIND_ALLOC, last: 1'b1};
            end
            state_nxt = ST_EMIT; ret_nxt = ST_IDLE;
          end
          ACT_UNREGISTER: begin
            if (!in_range || !used_r[s_idx] || owner_rd_r != own_r) begin
              ob_nxt = '{result_slot: slot_in_r, kind: KIND_MISMATCH, last: 1'b1};
              state_nxt = ST_EMIT;
            end else begin
              used_nxt[s_idx] = 1'b0;
              ob_nxt = '{result_slot: slot_in_r, kind: KIND_DONE, last: 1'b1};
              state_nxt = inl_r[s_idx] ? ST_UNLINK_RD : ST_EMIT;
            end
            ret_nxt = ST_EMIT;
          end
          ACT_CLOSE: begin
            ob_nxt = '{result_slot: slot_in_r, kind: KIND_DONE, last: 1'b1};
            ret_nxt = ST_EMIT;
            state_nxt = (in_range && inl_r[s_idx]) ? ST_UNLINK_RD : ST_EMIT;
          end
          ACT_USE: begin
            ob_nxt = '{result_slot: slot_in_r, kind: KIND_DONE, last: 1'b1};
            if (!in_range || !used_r[s_idx]) begin
              state_nxt = ST_EMIT;
            end else if (inl_r[s_idx]) begin
              ret_nxt = ST_PUSH; state_nxt = ST_UNLINK_RD;
            end else begin
              state_nxt = ST_EVICT;
            end
          end
          ACT_RELEASE: begin
            scan_nxt = '0; scan_done_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
          default: begin
            ob_nxt = '{result_slot: 5'd0, kind: KIND_DONE, last: 1'b1};
            state_nxt = ST_EMIT;
          end
        endcase
      end
      ST_EVICT: begin
        // evict oldest while list is at capacity
        if (!ov_r || out_ready) begin
          if (count_r >= CW'(cap) && count_r != '0) begin
            ob_nxt = '{result_slot: 5'(oldest_r), kind: KIND_RELEASED, last: 1'b0};
            ov_nxt = 1'b1;
            tgt_nxt = oldest_r;
            ret_nxt = ST_EVICT; state_nxt = ST_UNLINK_RD;
          end else begin
            ob_nxt = '{result_slot: slot_in_r, kind: KIND_DONE, last: 1'b1};
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_UNLINK_RD: begin
        // links of target being read
        state_nxt = ST_UNLINK_WR;
      end
      ST_UNLINK_WR: begin
        if (tgt_r != newest_r) begin
          d_we = 1'b1; d_wa = newer_rd_r; d_wd = older_rd_r;
        end else begin
          newest_nxt = older_rd_r;
        end
        if (tgt_r != oldest_r) begin
          n_we = 1'b1; n_wa = older_rd_r; n_wd = newer_rd_r;
        end else begin
          oldest_nxt = newer_rd_r;
        end
        inl_nxt[tgt_r] = 1'b0;
        count_nxt = count_r - 1'b1;
        if (count_r == CW'(1)) begin
          newest_nxt = '0; oldest_nxt = '0;
        end
        state_nxt = ret_r;
      end
      ST_PUSH: begin
        if (count_r == '0) begin
          oldest_nxt = s_idx;
        end else begin
          d_we = 1'b1; d_wa = s_idx; d_wd = newest_r;
          n_we = 1'b1; n_wa = newest_r; n_wd = s_idx;
        end
        newest_nxt = s_idx;
        inl_nxt[s_idx] = 1'b1;
        count_nxt = count_r + 1'b1;
        ob_nxt = '{result_slot: slot_in_r, kind: KIND_DONE, last: 1'b1};
        state_nxt = ST_EMIT;
      end
      ST_SCAN: begin
        // read owner of scan slot
        o_ra = scan_r;
        if (scan_done_r) begin
          if (!ov_r || out_ready) begin
            ob_nxt = '{result_slot: 5'd0, kind: KIND_DONE, last: 1'b1};
            ov_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        o_ra = scan_r;
        if (!ov_r || out_ready) begin
          if (used_r[scan_r] && owner_rd_r == own_r) begin
            ob_nxt = '{result_slot: 5'(scan_r), kind: KIND_RELEASED, last: 1'b0};
            ov_nxt = 1'b1;
            if (inl_r[scan_r]) begin
              tgt_nxt = scan_r; ret_nxt = ST_SCAN; state_nxt = ST_UNLINK_RD;
            end else begin
              state_nxt = ST_SCAN;
            end
          end else begin
            state_nxt = ST_SCAN;
          end
          if (32'(scan_r) == SLOTS - 1) scan_done_nxt = 1'b1;
          else scan_nxt = scan_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // list count bounded by the slot count and matching the list bits
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= SLOTS) else $error("list count above slot count");
  a_inlist_used: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(inl_r) == 32'(count_r)) else $error("list count disagrees with list bits");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(state_r == ST_EMIT)) else $error("ready while result pending");

endmodule
`default_nettype wire

// File: test/tb_lru_open_handle_tracker.sv
// testbench for the lru open handle tracker: predicts every result word and checks it
`timescale 1ns / 1ps
module tb_lru_open_handle_tracker
  import loht_pkg::*;
();

  localparam int NSLOT = 32;
  localparam int SETTLE_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_data = '0;

  always #10 clk = ~clk;

  lru_open_handle_tracker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // shadow state of the tracker
  bit used_q [NSLOT];
  logic [7:0] owner_q [NSLOT];
  bit listed_q [NSLOT];
  logic [4:0] newer_q [NSLOT];
  logic [4:0] older_q [NSLOT];
  logic [4:0] newest_q, oldest_q;
  int listed_cnt;
  logic [5:0] max_open_q;

  out_word_t expected_words[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  task automatic reset_shadow();
    for (int i = 0; i < NSLOT; i++) begin
      used_q[i] = 0; listed_q[i] = 0; owner_q[i] = '0; newer_q[i] = '0; older_q[i] = '0;
    end
    newest_q = '0; oldest_q = '0; listed_cnt = 0; max_open_q = MAX_OPEN_RESET;
  endtask

  task automatic push_word(logic [4:0] s, kind_t k);
    out_word_t w;
    w.result_slot = s; w.kind = k; w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  task automatic drop_from_list(logic [4:0] s);
    logic [4:0] nw, od;
    nw = newer_q[s]; od = older_q[s];
    if (listed_q[s]) begin
      if (s != newest_q) older_q[nw] = od; else newest_q = od;
      if (s != oldest_q) newer_q[od] = nw; else oldest_q = nw;
      listed_q[s] = 0;
      listed_cnt--;
      if (listed_cnt == 0) begin
        newest_q = '0; oldest_q = '0;
      end
    end
  endtask

  task automatic make_newest(logic [4:0] s);
    if (listed_cnt == 0) oldest_q = s;
    else begin
      older_q[s] = newest_q; newer_q[newest_q] = s;
    end
    newest_q = s; listed_q[s] = 1; listed_cnt++;
  endtask

  // predict the result words of one accepted word
  task automatic predict_tracker(in_word_t w);
    int cap, i;
    logic [4:0] victim;
    cap = (max_open_q == 0) ? 1 : (max_open_q > NSLOT ? NSLOT : max_open_q);
    case (w.action)
      ACT_REGISTER: begin
        for (i = 0; i < NSLOT; i++) if (!used_q[i]) break;
        if (i >= NSLOT) push_word('0, KIND_FULL);
        else begin
          used_q[i] = 1; owner_q[i] = w.owner; push_word(i[4:0], KIND_ALLOC);
        end
      end
      ACT_UNREGISTER: begin
        if (!used_q[w.slot] || owner_q[w.slot] != w.owner) push_word(w.slot, KIND_MISMATCH);
        else begin
          drop_from_list(w.slot); used_q[w.slot] = 0; push_word(w.slot, KIND_DONE);
        end
      end
      ACT_USE: begin
        if (used_q[w.slot]) begin
          if (listed_q[w.slot]) drop_from_list(w.slot);
          else
            while (listed_cnt >= cap && listed_cnt > 0) begin
              victim = oldest_q; push_word(victim, KIND_RELEASED); drop_from_list(victim);
            end
          make_newest(w.slot);
        end
        push_word(w.slot, KIND_DONE);
      end
      ACT_CLOSE: begin
        drop_from_list(w.slot); push_word(w.slot, KIND_DONE);
      end
      ACT_RELEASE: begin
        for (i = 0; i < NSLOT; i++)
          if (used_q[i] && owner_q[i] == w.owner) begin
            push_word(i[4:0], KIND_RELEASED); drop_from_list(i[4:0]);
          end
        push_word('0, KIND_DONE);
      end
      default: push_word('0, KIND_DONE);
    endcase
    expected_words[$].last = 1'b1;
  endtask

  // send one word, with random idle before it
  task automatic send_word(logic [2:0] act, logic [4:0] s, logic [7:0] own);
    in_word_t w;
    w.action = act; w.slot = s; w.owner = own;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tracker(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_open(logic [5:0] v);
    wait_drained();
    cfg_we <= 1'b1; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_open_q = v;
  endtask

  // receiver: random stall plus optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        e = expected_words.pop_front();
        if (out_data.result_slot !== e.result_slot || out_data.kind !== e.kind ||
            out_data.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected slot %0d kind %0d last %0d, got slot %0d kind %0d last %0d",
                     e.result_slot, e.kind, e.last,
                     out_data.result_slot, out_data.kind, out_data.last);
        end
      end
    end
  end

  task automatic test_directed();
    send_word(ACT_USE, 5'd0, 8'd0);          // use of free slot
    send_word(ACT_UNREGISTER, 5'd31, 8'hff); // unregister of free slot
    for (int i = 0; i < 3; i++) send_word(ACT_REGISTER, 5'd0, 8'hff);
    send_word(ACT_REGISTER, 5'd31, 8'h00);
    send_word(ACT_USE, 5'd0, 8'd0);
    send_word(ACT_USE, 5'd1, 8'd0);
    send_word(ACT_USE, 5'd2, 8'd0);          // evicts at cap
    send_word(ACT_USE, 5'd3, 8'd0);
    send_word(ACT_USE, 5'd3, 8'd0);          // already listed
    send_word(ACT_CLOSE, 5'd2, 8'd0);
    send_word(ACT_CLOSE, 5'd2, 8'd0);        // close of unlisted slot
    send_word(ACT_UNREGISTER, 5'd1, 8'h00);  // owner mismatch
    send_word(ACT_UNREGISTER, 5'd3, 8'h00);
    send_word(ACT_RELEASE, 5'd0, 8'hff);
    send_word(3'd5, 5'd7, 8'h5a);
    send_word(3'd7, 5'd31, 8'ha5);
    send_word(3'd6, 5'd0, 8'h00);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 34; i++) send_word(ACT_REGISTER, 5'd0, 8'($urandom_range(3)));
    for (int i = 0; i < 34; i++) send_word(ACT_USE, 5'($urandom_range(31)), 8'd0);
    send_word(ACT_RELEASE, 5'd0, 8'd1);
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 20) send_word(ACT_REGISTER, 5'($urandom), 8'($urandom_range(3)));
      else if (r < 32) send_word(ACT_UNREGISTER, 5'($urandom),
                                 ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
      else if (r < 72) send_word(ACT_USE, 5'($urandom), 8'($urandom));
      else if (r < 84) send_word(ACT_CLOSE, 5'($urandom), 8'($urandom));
      else if (r < 94) send_word(ACT_RELEASE, 5'($urandom),
                                 ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
      else send_word(3'($urandom_range(7)), 5'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_word(ACT_USE, 5'($urandom), 8'd0);
    wait_drained();
    send_word(ACT_RELEASE, 5'd0, 8'd2);
  endtask

  initial begin
    reset_shadow();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 8; recv_idle_pct = 66;
    write_max_open(6'd2);
    test_directed();
    write_max_open(6'd0);
    test_random(60);
    write_max_open(6'd32);
    test_table_full();
    test_random(100);
    send_idle_pct = 66; recv_idle_pct = 8;
    write_max_open(6'd63);
    test_random(100);
    write_max_open(6'd1);
    test_backpressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_max_open(6'd5);
    test_random(100);
    write_max_open(6'd16);
    test_random(20);
    wait_drained();
    if (mismatches == 0 && expected_words.size() == 0)
      $display("lru_open_handle_tracker test passed");
    else
      $display("lru_open_handle_tracker test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("lru_open_handle_tracker test failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/loht_pkg.sv
rtl/lru_open_handle_tracker.sv
test/tb_lru_open_handle_tracker.sv
